// ----- rtl/table_driven_fsm_stepper_defines.svh -----
// ============================================================================
// Table-driven FSM stepper assertion macros
// Shared property macros for the port-level checker of the stepper.
// ============================================================================
`ifndef TABLE_DRIVEN_FSM_STEPPER_DEFINES_SVH
`define TABLE_DRIVEN_FSM_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TDFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper check failed");

// Next-cycle implication, disabled while reset is high.
`define TDFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepper check failed");

`endif

// ----- rtl/tdfs_pkg.sv -----
// ============================================================================
// Table-driven FSM stepper package
// Types, result codes and character constants shared by the stepper modules.
// ============================================================================
package tdfs_pkg;

   localparam int STATE_W  = 16;
   localparam int SYMBOL_W = 8;

   localparam logic [SYMBOL_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [SYMBOL_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [SYMBOL_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [SYMBOL_W-1:0] CHAR_LOWER_Z = 8'h7A;

   // Operation codes of an input item.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_LETTER = 2'd1,
      ST_NO_MATCH   = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   // One transition table entry.
   typedef struct packed {
      logic [STATE_W-1:0]  source;
      logic [SYMBOL_W-1:0] symbol;
      logic [STATE_W-1:0]  target;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       write;
      logic       scan_start;
      logic       scan_next;
      logic       take_target;
      logic       publish;
      status_type status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_step;
      logic letter;
      logic full;
      logic empty;
      logic match;
      logic last;
   } stat_type;

endpackage

// ----- rtl/tdfs_datapath.sv -----
// ============================================================================
// Table-driven FSM stepper datapath
// Holds the item, the transition table memory, the scan pointer, the current
// state and the result register.
// ============================================================================
module tdfs_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tdfs_pkg::cmd_type             cmd,
   output tdfs_pkg::stat_type            sts,
   input  logic                          req_op,
   input  logic [tdfs_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic [tdfs_pkg::STATE_W-1:0]  req_from_state,
   input  logic [tdfs_pkg::STATE_W-1:0]  req_to_state,
   output logic [tdfs_pkg::STATE_W-1:0]  rsp_state_out,
   output logic [1:0]                    rsp_status
);

   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                          op_ff;
   logic [tdfs_pkg::SYMBOL_W-1:0] symbol_ff;
   logic [tdfs_pkg::STATE_W-1:0]  from_ff;
   logic [tdfs_pkg::STATE_W-1:0]  to_ff;

   tdfs_pkg::entry_type           table_mem [TABLE_DEPTH];
   tdfs_pkg::entry_type           rd_data_ff;
   tdfs_pkg::entry_type           wr_data;

   logic [CntW-1:0]               count_ff;
   logic [CntW-1:0]               scan_idx_ff;
   logic [CntW-1:0]               rd_idx_ff;
   logic [tdfs_pkg::STATE_W-1:0]  cur_state_ff;
   logic [tdfs_pkg::STATE_W-1:0]  rsp_state_ff;
   logic [1:0]                    rsp_status_ff;

   assign wr_data.source = from_ff;
   assign wr_data.symbol = symbol_ff;
   assign wr_data.target = to_ff;

   // Item capture and result registers carry payload only.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         symbol_ff <= req_symbol;
         from_ff   <= req_from_state;
         to_ff     <= req_to_state;
      end
      if (cmd.publish) begin
         rsp_state_ff  <= cur_state_ff;
         rsp_status_ff <= cmd.status;
      end
   end

   // Table memory: one write port at the fill count, one registered read port
   // at the scan pointer.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         table_mem[count_ff[IdxW-1:0]] <= wr_data;
      end
      rd_data_ff <= table_mem[scan_idx_ff[IdxW-1:0]];
   end

   // Scan pointer; rd_idx_ff names the entry now held in rd_data_ff.
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_idx_ff <= scan_idx_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cur_state_ff <= '0;
      end else begin
         if (cmd.write) begin
            count_ff <= count_ff + CntW'(1);
         end
         if (cmd.take_target) begin
            cur_state_ff <= rd_data_ff.target;
         end
      end
   end

   assign sts.is_step = (op_ff == tdfs_pkg::OP_STEP);
   assign sts.letter  = ((symbol_ff >= tdfs_pkg::CHAR_UPPER_A) &&
                         (symbol_ff <= tdfs_pkg::CHAR_UPPER_Z)) ||
                        ((symbol_ff >= tdfs_pkg::CHAR_LOWER_A) &&
                         (symbol_ff <= tdfs_pkg::CHAR_LOWER_Z));
   assign sts.full    = (count_ff == CntW'(TABLE_DEPTH));
   assign sts.empty   = (count_ff == '0);
   assign sts.match   = (rd_data_ff.source == cur_state_ff) &&
                        (rd_data_ff.symbol == symbol_ff);
   assign sts.last    = ((rd_idx_ff + CntW'(1)) == count_ff);

   assign rsp_state_out = rsp_state_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- rtl/tdfs_ctrl.sv -----
// ============================================================================
// Table-driven FSM stepper controller
// Sequences one item: decode, optional table scan, and result hand-off.
// ============================================================================
module tdfs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tdfs_pkg::stat_type sts,
   output tdfs_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FILL,
      S_SCAN,
      S_FINISH
   } ctrl_state_type;

   ctrl_state_type       state_ff;
   ctrl_state_type       state_in;
   tdfs_pkg::status_type status_ff;
   tdfs_pkg::status_type status_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.is_step) begin
               if (sts.full) begin
                  status_in = tdfs_pkg::ST_FULL;
               end else begin
                  cmd.write = 1'b1;
                  status_in = tdfs_pkg::ST_OK;
               end
               state_in = S_FINISH;
            end else if (!sts.letter) begin
               status_in = tdfs_pkg::ST_NOT_LETTER;
               state_in  = S_FINISH;
            end else if (sts.empty) begin
               status_in = tdfs_pkg::ST_NO_MATCH;
               state_in  = S_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_FILL;
            end
         end
         S_FILL: begin
            cmd.scan_next = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (sts.match) begin
               cmd.take_target = 1'b1;
               status_in       = tdfs_pkg::ST_OK;
               state_in        = S_FINISH;
            end else if (sts.last) begin
               status_in = tdfs_pkg::ST_NO_MATCH;
               state_in  = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= tdfs_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/table_driven_fsm_stepper.sv -----
// ============================================================================
// Table-driven FSM stepper: a load or rejected step passes decode and finish;
// a step with a letter symbol also scans the filled table entries in order.
// Throughput: one item at a time; the next item enters the cycle after publish.
// Synchronous active-high reset empties the table and sets the state to zero.
// ============================================================================
module table_driven_fsm_stepper #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_from_state,
   input  logic [15:0] req_to_state,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_state_out,
   output logic [1:0]  rsp_status
);

   // The block is split into a controller that sequences each item and a
   // datapath that owns the table memory, the current state and the result
   // register. They talk only through the command and status structs below.
   //
   // A load item appends one entry at the fill count, or reports a full table.
   // A step item with a letter symbol scans the table from the first entry,
   // one entry per cycle through the registered memory read port, and stops
   // at the first entry whose source and symbol match. The scan length, and
   // so the step latency, is bounded by how many entries have been loaded.
   //
   // Entries that were never loaded are never compared, so the memory needs
   // no clearing pass after reset.
   //
   // The result sits in an output register; the controller returns to idle
   // as soon as the result is loaded there, so a new item can be accepted
   // while the previous result is still waiting to be taken.

   tdfs_pkg::cmd_type  cmd;
   tdfs_pkg::stat_type sts;

   tdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdfs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_symbol     (req_symbol),
      .req_from_state (req_from_state),
      .req_to_state   (req_to_state),
      .rsp_state_out  (rsp_state_out),
      .rsp_status     (rsp_status)
   );

endmodule

// ----- rtl/tdfs_checker.sv -----
// ============================================================================
// Table-driven FSM stepper port checker
// Watches the handshakes at the top-level ports and flags sequencing slips.
// ============================================================================
`include "table_driven_fsm_stepper_defines.svh"

module tdfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_state_out,
   input logic [1:0]  rsp_status
);

   // A stalled result stays offered and unchanged.
   `TDFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_state_out) && $stable(rsp_status))

   // Once an item is taken the block is busy for at least the next cycle.
   `TDFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // No result can be produced in the cycle right after an item is taken.
   `TDFS_ASSERT_NEXT(a_no_early_result, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

   // A fresh result is only ever loaded when the block is going idle.
   `TDFS_ASSERT_NOW(a_result_idle, clock, reset, $rose(rsp_valid), !req_stall)

endmodule

bind table_driven_fsm_stepper tdfs_checker u_checker (.*);

// ----- sim/tb.sv -----
// ============================================================================
// Testbench for the table-driven FSM stepper
// Loads transition entries and steps the machine with symbols, predicts each
// result with an independent model of the table search, and checks every
// result item in order while both channels idle and stall at random.
// ============================================================================
module tb;

   localparam int TABLE_DEPTH   = 256;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int REPORT_LIMIT  = 10;

   // One input item as the sender sees it. The drain flag makes the sender
   // wait until every outstanding result has arrived before offering it.
   typedef struct {
      logic                          op;
      logic [tdfs_pkg::SYMBOL_W-1:0] symbol;
      logic [tdfs_pkg::STATE_W-1:0]  from_state;
      logic [tdfs_pkg::STATE_W-1:0]  to_state;
      bit                            drain;
   } stimulus_type;

   typedef struct {
      logic [tdfs_pkg::STATE_W-1:0] state_out;
      tdfs_pkg::status_type         status;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = tdfs_pkg::OP_LOAD;
   logic [7:0]  req_symbol = '0;
   logic [15:0] req_from_state = '0;
   logic [15:0] req_to_state = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_state_out;
   logic [1:0]  rsp_status;

   table_driven_fsm_stepper #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_symbol    (req_symbol),
      .req_from_state(req_from_state),
      .req_to_state  (req_to_state),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_state_out (rsp_state_out),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Transition table predictor. The table only grows, so the entry index is
   // also the load order, and the first matching index wins a search.
   // ------------------------------------------------------------------------
   logic [tdfs_pkg::STATE_W-1:0]  rule_source [TABLE_DEPTH];
   logic [tdfs_pkg::SYMBOL_W-1:0] rule_symbol [TABLE_DEPTH];
   logic [tdfs_pkg::STATE_W-1:0]  rule_target [TABLE_DEPTH];
   int                            rule_count = 0;
   logic [tdfs_pkg::STATE_W-1:0]  machine_state = '0;

   function automatic bit is_letter(logic [tdfs_pkg::SYMBOL_W-1:0] c);
      return (c >= tdfs_pkg::CHAR_UPPER_A && c <= tdfs_pkg::CHAR_UPPER_Z) ||
             (c >= tdfs_pkg::CHAR_LOWER_A && c <= tdfs_pkg::CHAR_LOWER_Z);
   endfunction

   function automatic outcome_type apply_item(stimulus_type it);
      outcome_type res;
      res.status = tdfs_pkg::ST_OK;
      if (it.op == tdfs_pkg::OP_LOAD) begin
         // A full table drops the entry; otherwise it is appended.
         if (rule_count >= TABLE_DEPTH) begin
            res.status = tdfs_pkg::ST_FULL;
         end else begin
            rule_source[rule_count] = it.from_state;
            rule_symbol[rule_count] = it.symbol;
            rule_target[rule_count] = it.to_state;
            rule_count++;
         end
      end else if (!is_letter(it.symbol)) begin
         // Symbols outside the two letter ranges never reach the search.
         res.status = tdfs_pkg::ST_NOT_LETTER;
      end else begin
         res.status = tdfs_pkg::ST_NO_MATCH;
         for (int k = 0; k < rule_count; k++) begin
            if (rule_source[k] == machine_state && rule_symbol[k] == it.symbol) begin
               machine_state = rule_target[k];
               res.status = tdfs_pkg::ST_OK;
               break;
            end
         end
      end
      res.state_out = machine_state;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus generation. Random loads mostly draw states from a small pool and
   // symbols from a small alphabet so that steps mostly find a transition and
   // the machine keeps walking a connected graph instead of getting stuck.
   // ------------------------------------------------------------------------
   stimulus_type pending_items[$];
   outcome_type  outcomes_due[$];
   int           loads_queued = 0;
   int           fail_count = 0;

   logic [tdfs_pkg::STATE_W-1:0]  state_pool [8] = '{16'h0000, 16'h0001, 16'h0002,
                                                     16'h0003, 16'h0004, 16'h0005,
                                                     16'h8000, 16'hFFFF};
   logic [tdfs_pkg::SYMBOL_W-1:0] letter_set [6] = '{tdfs_pkg::CHAR_UPPER_A,
                                                     tdfs_pkg::CHAR_UPPER_Z,
                                                     tdfs_pkg::CHAR_LOWER_A,
                                                     tdfs_pkg::CHAR_LOWER_Z,
                                                     8'h6D, 8'h42};

   function automatic logic [tdfs_pkg::STATE_W-1:0] pick_state();
      return state_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [tdfs_pkg::SYMBOL_W-1:0] pick_letter();
      return letter_set[$urandom_range(0, 5)];
   endfunction

   task automatic queue_item(logic op, logic [tdfs_pkg::SYMBOL_W-1:0] sym,
                             logic [tdfs_pkg::STATE_W-1:0] src,
                             logic [tdfs_pkg::STATE_W-1:0] dst,
                             bit drain = 1'b0);
      stimulus_type it;
      it = '{op, sym, src, dst, drain};
      pending_items.push_back(it);
      if (op == tdfs_pkg::OP_LOAD) begin
         loads_queued++;
      end
   endtask

   task automatic queue_random_load();
      logic [tdfs_pkg::SYMBOL_W-1:0] sym;
      logic [tdfs_pkg::STATE_W-1:0]  dst;
      if ($urandom_range(0, 9) == 0) begin
         // Wide random content. A letter entry still targets a pool state so
         // that taking it never strands the machine in an unreachable state.
         sym = 8'($urandom_range(0, 255));
         dst = is_letter(sym) ? pick_state() : 16'($urandom_range(0, 65535));
         queue_item(tdfs_pkg::OP_LOAD, sym, 16'($urandom_range(0, 65535)), dst);
      end else begin
         queue_item(tdfs_pkg::OP_LOAD, pick_letter(), pick_state(), pick_state());
      end
   endtask

   // ------------------------------------------------------------------------
   // Sender. Items go out in bursts of random length with random gaps, and an
   // offered item holds its payload until it is accepted. The monitor counts
   // accepted items, so an offer is still open while the counts differ.
   // ------------------------------------------------------------------------
   int           sent_count = 0;
   int           taken_count = 0;
   int           burst_left = 1;
   int           gap_left = 0;
   stimulus_type next_item;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && taken_count != sent_count) begin
         // Still waiting for the block to take the current item.
      end else begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0 ||
                      (pending_items[0].drain && outcomes_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_item = pending_items.pop_front();
            sent_count++;
            req_valid      <= 1'b1;
            req_op         <= next_item.op;
            req_symbol     <= next_item.symbol;
            req_from_state <= next_item.from_state;
            req_to_state   <= next_item.to_state;
            burst_left--;
            if (burst_left <= 0) begin
               // Now and then a long burst gives a stretch with no idling.
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. The stall pattern switches between free running, light and
   // heavy random stalling, and strict alternation.
   // ------------------------------------------------------------------------
   int stall_mode = 0;
   int stall_span = 0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 200);
      end
      stall_span--;
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= ~rsp_stall;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Monitor. Accepted input items feed the predictor; accepted result items
   // are checked against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      stimulus_type seen;
      outcome_type  want;
      if (!reset && req_valid && !req_stall) begin
         seen = '{req_op, req_symbol, req_from_state, req_to_state, 1'b0};
         outcomes_due.push_back(apply_item(seen));
         taken_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected result item state_out=%h status=%0d",
                        $realtime, rsp_state_out, rsp_status);
            end
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_state_out !== want.state_out || rsp_status !== want.status) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch state_out exp %h got %h, status exp %0d got %0d",
                           $realtime, want.state_out, rsp_state_out, want.status,
                           rsp_status);
               end
            end
         end
      end
   end

   // A run that stops making progress ends here.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence: directed items, then random items, then the drain.
   // ------------------------------------------------------------------------
   initial begin
      bit take_load;

      // Stepping an empty table finds nothing; a zero byte is not a letter.
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_UPPER_A, 16'hFFFF, 16'hFFFF);
      queue_item(tdfs_pkg::OP_STEP, 8'h00, 16'h0000, 16'h0000);
      // Duplicate source and symbol: the entry loaded first must win.
      queue_item(tdfs_pkg::OP_LOAD, tdfs_pkg::CHAR_UPPER_A, 16'h0000, 16'hFFFF);
      queue_item(tdfs_pkg::OP_LOAD, tdfs_pkg::CHAR_UPPER_A, 16'h0000, 16'h0001);
      queue_item(tdfs_pkg::OP_LOAD, tdfs_pkg::CHAR_LOWER_Z, 16'hFFFF, 16'h0000);
      // An entry with a non-letter symbol is stored but can never match.
      queue_item(tdfs_pkg::OP_LOAD, 8'hFF, 16'h0000, 16'hFFFF);
      queue_item(tdfs_pkg::OP_LOAD, tdfs_pkg::CHAR_UPPER_Z, 16'h0000, 16'h0005);
      queue_item(tdfs_pkg::OP_LOAD, tdfs_pkg::CHAR_LOWER_A, 16'h0005, 16'h8000);
      queue_item(tdfs_pkg::OP_LOAD, 8'h6D, 16'h8000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_UPPER_A, 16'h1234, 16'hEDCB);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_UPPER_A, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_LOWER_Z, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, 8'hFF, 16'h0000, 16'h0000);
      // The bytes just outside both letter ranges are all rejected.
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_UPPER_A - 8'd1, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_UPPER_Z + 8'd1, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_LOWER_A - 8'd1, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_LOWER_Z + 8'd1, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_UPPER_Z, 16'h0000, 16'h0000);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_LOWER_A, 16'h0000, 16'h0000);
      // This one waits until the block has handed back every result.
      queue_item(tdfs_pkg::OP_STEP, 8'h6D, 16'h0000, 16'h0000, 1'b1);
      queue_item(tdfs_pkg::OP_STEP, tdfs_pkg::CHAR_LOWER_A, 16'h0000, 16'h0000);

      // Loads are frequent until the table fills, then rare so that the
      // table full case keeps coming up while most items walk the machine.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         take_load = (loads_queued < TABLE_DEPTH) ? ($urandom_range(0, 4) < 2)
                                                  : ($urandom_range(0, 24) == 0);
         if (take_load) begin
            queue_random_load();
         end else begin
            queue_item(tdfs_pkg::OP_STEP,
                       ($urandom_range(0, 19) < 17) ? pick_letter()
                                                    : 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         end
         if (n % 450 == 0) begin
            pending_items[$].drain = 1'b1;
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || outcomes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && outcomes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
